// ----- rtl/core/twq_pkg.sv -----
// Shared types and constants for the task wait queue.
// Depends on nothing; used by task_wait_queue_core.
`default_nettype none

package twq_pkg;

  // Default sizes handed to the top-level parameters
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned TASK_ID_WIDTH_DEF = 8;

  // Request codes carried on in_tuser
  typedef enum logic [1:0] {
    REQ_SLEEP    = 2'd0,
    REQ_WAKE_ONE = 2'd1,
    REQ_WAKE_ALL = 2'd2
  } req_t;

  // Result status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_TASK = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECIDE = 2'd1,
    S_FETCH  = 2'd2
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/twq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the task identifier ring of the wait queue.
`default_nettype none

module twq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/task_wait_queue_core.sv -----
// Task wait queue: ring of waiting task identifiers with sleep, wake-one and wake-all.
// Depends on twq_pkg and twq_ram.
`default_nettype none

// Usage: one request enters on the in_ stream (in_tuser = request code) and the
// block then stays busy until its last result has been loaded into the output
// register. A sleep or an empty wake loads its result from the decide state; a
// wake-one reads the oldest slot in the decide state and loads its result from
// the fetch state; a wake-all loads its first result in the same way and then
// one result per cycle while out_tready stays high. A loaded result that waits
// on out_tready holds back the next load. This pace is set by the registered
// read of the slot RAM and by the single ring-index adder that the sequencer
// uses for both the tail slot and the head advance. The next request is taken
// in the cycle after the last result is loaded, even if that result still
// waits on out_tready. Results of one request end with out_tlast high; unused
// request codes give no result.

module task_wait_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = twq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_ID_WIDTH = twq_pkg::TASK_ID_WIDTH_DEF,
  localparam int unsigned IW     = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IN_FW  = TASK_ID_WIDTH + 1,
  localparam int unsigned IN_DW  = ((IN_FW + 7) / 8) * 8,
  localparam int unsigned OUT_FW = 1 + TASK_ID_WIDTH + CW,
  localparam int unsigned OUT_DW = ((OUT_FW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // task_present, task_id, zero fill
  input  wire logic [1:0]        in_tuser,   // req_type
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // woken_valid, woken_task, waiting_count, zero fill
  output logic      [1:0]        out_tuser,  // status
  output logic                   out_tlast
);

  // Sequencer and queue state
  twq_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  // Latched request
  twq_pkg::req_t            req_r, req_nxt;
  logic                     present_r, present_nxt;
  logic [TASK_ID_WIDTH-1:0] tid_r, tid_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic                     wvalid_r, wvalid_nxt;
  logic [TASK_ID_WIDTH-1:0] wtask_r, wtask_nxt;
  logic                     last_r, last_nxt;
  twq_pkg::status_t         status_r, status_nxt;
  logic [CW-1:0]            wcount_r, wcount_nxt;

  // Shared ring-index adder
  logic [CW:0]   unit_a, unit_b, unit_raw;
  logic [IW-1:0] unit_idx;

  // RAM port signals
  logic                     ram_we, ram_re;
  logic [IW-1:0]            ram_waddr, ram_raddr;
  logic [TASK_ID_WIDTH-1:0] ram_rdata;

  logic out_free;
  logic pop_last;

  twq_ram #(
    .WIDTH (TASK_ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (tid_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Ring add: head plus count for the tail slot, head plus one for advance
  always_comb begin
    unit_a = {{(CW + 1 - IW){1'b0}}, head_r};
    if (state_r == twq_pkg::S_DECIDE) begin
      unit_b = {1'b0, count_r};
    end else begin
      unit_b = (CW + 1)'(1);
    end
    unit_raw = unit_a + unit_b;
    if (unit_raw >= (CW + 1)'(QUEUE_DEPTH)) begin
      unit_idx = IW'(unit_raw - (CW + 1)'(QUEUE_DEPTH));
    end else begin
      unit_idx = unit_raw[IW-1:0];
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign pop_last  = (req_r == twq_pkg::REQ_WAKE_ONE) || (count_r == CW'(1));
  assign in_tready = (state_r == twq_pkg::S_IDLE);

  // Sequencer: next state, queue update and result loading
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    present_nxt   = present_r;
    tid_nxt       = tid_r;
    out_valid_nxt = out_valid_r;
    wvalid_nxt    = wvalid_r;
    wtask_nxt     = wtask_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    wcount_nxt    = wcount_r;
    ram_we        = 1'b0;
    ram_waddr     = unit_idx;
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      twq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          req_nxt     = twq_pkg::req_t'(in_tuser);
          present_nxt = in_tdata[0];
          tid_nxt     = in_tdata[TASK_ID_WIDTH:1];
          state_nxt   = twq_pkg::S_DECIDE;
        end
      end
      twq_pkg::S_DECIDE: begin
        case (req_r)
          twq_pkg::REQ_SLEEP: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              wvalid_nxt    = 1'b0;
              wtask_nxt     = '0;
              last_nxt      = 1'b1;
              wcount_nxt    = count_r;
              state_nxt     = twq_pkg::S_IDLE;
              if (!present_r) begin
                status_nxt = twq_pkg::ST_NO_TASK;
              end else if (count_r == CW'(QUEUE_DEPTH)) begin
                status_nxt = twq_pkg::ST_FULL;
              end else begin
                // append at the tail slot
                ram_we     = 1'b1;
                count_nxt  = count_r + CW'(1);
                wcount_nxt = count_r + CW'(1);
                status_nxt = twq_pkg::ST_OK;
              end
            end
          end
          twq_pkg::REQ_WAKE_ONE, twq_pkg::REQ_WAKE_ALL: begin
            if (count_r == '0) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                wvalid_nxt    = 1'b0;
                wtask_nxt     = '0;
                last_nxt      = 1'b1;
                status_nxt    = twq_pkg::ST_EMPTY;
                wcount_nxt    = '0;
                state_nxt     = twq_pkg::S_IDLE;
              end
            end else begin
              // fetch the oldest task
              ram_re    = 1'b1;
              state_nxt = twq_pkg::S_FETCH;
            end
          end
          default: begin
            state_nxt = twq_pkg::S_IDLE;
          end
        endcase
      end
      twq_pkg::S_FETCH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          wvalid_nxt    = 1'b1;
          wtask_nxt     = ram_rdata;
          last_nxt      = pop_last;
          status_nxt    = twq_pkg::ST_OK;
          wcount_nxt    = count_r - CW'(1);
          count_nxt     = count_r - CW'(1);
          head_nxt      = unit_idx;
          if (pop_last) begin
            state_nxt = twq_pkg::S_IDLE;
          end else begin
            // prefetch the next oldest
            ram_re    = 1'b1;
            ram_raddr = unit_idx;
          end
        end
      end
      default: begin
        state_nxt = twq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twq_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    present_r <= present_nxt;
    tid_r     <= tid_nxt;
    wvalid_r  <= wvalid_nxt;
    wtask_r   <= wtask_nxt;
    last_r    <= last_nxt;
    status_r  <= status_nxt;
    wcount_r  <= wcount_nxt;
  end

  // Pack the result stream
  always_comb begin
    out_tdata               = '0;
    out_tdata[OUT_FW-1:0]   = {wcount_r, wtask_r, wvalid_r};
  end
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("waiting count above queue depth");

  a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && wvalid_r |-> status_r == twq_pkg::ST_OK)
    else $error("woken task with non-ok status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == twq_pkg::ST_EMPTY |-> wcount_r == '0 && last_r)
    else $error("empty result with tasks left or not last");

  a_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> wvalid_r && wcount_r != '0 && state_r != twq_pkg::S_IDLE)
    else $error("non-final wake-all result inconsistent");

endmodule

`default_nettype wire
